>>> rtl/smrc_pkg.sv
// Package for the sorted multiset range count unit.
// Holds request modes, result status codes and shared widths.
// No dependencies.
`default_nettype none
package smrc_pkg;

    localparam int unsigned KeyWidth = 32;
    localparam int unsigned CountWidth = 32;

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_ERASE_ONE = 2'd1,
        MODE_ERASE_RANGE = 2'd2,
        MODE_COUNT_RANGE = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_OK = 2'd0,
        STATUS_FULL = 2'd1,
        STATUS_ABSENT = 2'd2
    } status_t;

endpackage
`default_nettype wire

>>> rtl/smrc_store.sv
// Entry memory of the multiset: one synchronous memory of key and count pairs.
// One write port and one read port, read data registered; uses smrc_pkg.
`default_nettype none
module smrc_store #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned AW = 6
) (
    input  wire logic                               aclk,
    input  wire logic                               wr_en,
    input  wire logic [AW-1:0]                      wr_addr,
    input  wire logic [smrc_pkg::KeyWidth-1:0]      wr_key,
    input  wire logic [smrc_pkg::CountWidth-1:0]    wr_count,
    input  wire logic [AW-1:0]                      rd_addr,
    output logic      [smrc_pkg::KeyWidth-1:0]      rd_key,
    output logic      [smrc_pkg::CountWidth-1:0]    rd_count
);

    logic [smrc_pkg::KeyWidth+smrc_pkg::CountWidth-1:0] mem [DEPTH];
    logic [smrc_pkg::KeyWidth+smrc_pkg::CountWidth-1:0] rd_reg;

    // Synchronous write and registered read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {wr_key, wr_count};
        end
        rd_reg <= mem[rd_addr];
    end

    assign rd_key = rd_reg[smrc_pkg::KeyWidth+smrc_pkg::CountWidth-1:smrc_pkg::CountWidth];
    assign rd_count = rd_reg[smrc_pkg::CountWidth-1:0];

endmodule
`default_nettype wire

>>> rtl/sorted_multiset_range_count_unit.sv
// Sorted multiset range count unit: top level with the sequencer and entry memory.
// Scans entries one a cycle, then shifts the tail one entry a cycle.
// One item at a time; the result waits in its own output register, so the next
// item can be taken while it waits. Reset (aresetn, synchronous) empties the
// table at once; memory contents need no clearing.
`default_nettype none
module sorted_multiset_range_count_unit #(
    parameter int unsigned CAPACITY = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // tdata: mode [1:0], value_a [33:2], value_b [65:34], zeros [71:66]
    input  wire logic [71:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // tdata: total [31:0], status [33:32], zeros [39:34]
    output logic      [39:0] m_tdata
);

    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CapCount = CW'(CAPACITY);
    localparam logic [31:0] CountMax = 32'hFFFF_FFFF;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_SCAN  = 7'b0000010,
        ST_DEC   = 7'b0000100,
        ST_SHR   = 7'b0001000,
        ST_SHL   = 7'b0010000,
        ST_WRNEW = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] occ_reg, occ_next;
    logic [CW-1:0] idx_reg, idx_next;       // scan position or shift cursor
    logic [CW-1:0] lo_reg, lo_next;         // first entry not below value_a
    logic [CW-1:0] hi_reg, hi_next;         // first entry not below value_b
    logic          lo_found_reg, lo_found_next;
    logic          rd_pend_reg, rd_pend_next;
    logic [1:0]    mode_reg;
    logic signed [31:0] a_reg, b_reg;
    logic [32:0]   sum_reg, sum_next;
    logic [31:0]   total_reg, total_next;
    logic [1:0]    status_reg, status_next;
    logic          mv_reg, mv_next;
    logic [31:0]   out_total_reg;
    logic [1:0]    out_status_reg;
    logic          out_load;

    logic          wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [31:0]   wr_key, wr_count, rd_key, rd_count;
    logic          accept;

    smrc_store #(.DEPTH(CAPACITY), .AW(AW)) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_key  (wr_key),
        .wr_count(wr_count),
        .rd_addr (rd_addr),
        .rd_key  (rd_key),
        .rd_count(rd_count)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign accept = s_tvalid && s_tready;
    assign m_tvalid = mv_reg;
    assign m_tdata = {6'd0, out_status_reg, out_total_reg};

    // Sequencer: linear scan, then tail shifts through the entry memory.
    always_comb begin
        logic signed [31:0] key_s;
        logic [32:0] sum_add;
        logic is_range;
        state_next = state_reg;
        occ_next = occ_reg;
        idx_next = idx_reg;
        lo_next = lo_reg;
        hi_next = hi_reg;
        lo_found_next = lo_found_reg;
        rd_pend_next = 1'b0;
        sum_next = sum_reg;
        total_next = total_reg;
        status_next = status_reg;
        mv_next = mv_reg && !m_tready;
        out_load = 1'b0;
        wr_en = 1'b0;
        wr_addr = idx_reg[AW-1:0];
        wr_key = rd_key;
        wr_count = rd_count;
        rd_addr = idx_reg[AW-1:0];
        key_s = rd_key;
        sum_add = sum_reg + {1'b0, rd_count};
        is_range = mode_reg[1];
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    idx_next = '0;
                    lo_found_next = 1'b0;
                    sum_next = '0;
                    rd_addr = '0;
                    rd_pend_next = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // rd data is entry idx; issued last cycle.
                if (idx_reg < occ_reg && (!lo_found_reg || (is_range && key_s < b_reg))) begin
                    if (!lo_found_reg && !(key_s < a_reg)) begin
                        lo_found_next = 1'b1;
                        lo_next = idx_reg;
                    end
                    if (!lo_found_reg && !(key_s < a_reg) && !is_range) begin
                        // Single key reached: decide.
                        state_next = ST_DEC;
                    end else begin
                        if (is_range && !(key_s < a_reg) && key_s < b_reg) begin
                            sum_next = sum_add[32] ? {1'b0, CountMax} : sum_add;
                        end
                        if (!(lo_found_reg || !(key_s < a_reg)) || key_s < b_reg
                            || !is_range) begin
                            idx_next = idx_reg + 1'b1;
                            rd_addr = AW'(idx_reg + 1'b1);
                        end
                    end
                end else begin
                    if (!lo_found_reg) begin
                        lo_next = idx_reg;
                    end
                    hi_next = idx_reg;
                    state_next = ST_DEC;
                end
            end
            ST_DEC: begin
                state_next = ST_DONE;
                if (mode_reg == smrc_pkg::MODE_INSERT) begin
                    if (lo_found_reg && key_s == a_reg) begin
                        wr_en = 1'b1;
                        wr_addr = lo_reg[AW-1:0];
                        wr_count = (rd_count == CountMax) ? rd_count : rd_count + 1'b1;
                    end else if (occ_reg >= CapCount) begin
                        status_next = smrc_pkg::STATUS_FULL;
                    end else begin
                        // Shift tail right from the top, then write the new key.
                        idx_next = occ_reg;
                        occ_next = occ_reg + 1'b1;
                        state_next = ST_SHR;
                        rd_addr = AW'(occ_reg - 1'b1);
                        rd_pend_next = 1'b1;
                    end
                end else if (mode_reg == smrc_pkg::MODE_ERASE_ONE) begin
                    if (lo_found_reg && key_s == a_reg) begin
                        if (rd_count > 32'd1) begin
                            wr_en = 1'b1;
                            wr_addr = lo_reg[AW-1:0];
                            wr_count = rd_count - 1'b1;
                        end else begin
                            hi_next = lo_reg + 1'b1;
                            idx_next = lo_reg;
                            rd_addr = AW'(lo_reg + 1'b1);
                            rd_pend_next = 1'b1;
                            state_next = ST_SHL;
                        end
                    end else begin
                        status_next = smrc_pkg::STATUS_ABSENT;
                    end
                end else if (a_reg < b_reg) begin
                    if (mode_reg == smrc_pkg::MODE_COUNT_RANGE) begin
                        total_next = sum_reg[31:0];
                    end else if (hi_reg > lo_reg) begin
                        idx_next = lo_reg;
                        rd_addr = AW'(hi_reg);
                        rd_pend_next = 1'b1;
                        state_next = ST_SHL;
                    end
                end
            end
            ST_SHR: begin
                // Read of entry idx-1 is pending or present.
                if (idx_reg == lo_reg) begin
                    state_next = ST_WRNEW;
                end else if (rd_pend_reg) begin
                    wr_en = 1'b1;
                    wr_addr = idx_reg[AW-1:0];
                    idx_next = idx_reg - 1'b1;
                    if (idx_reg - 1'b1 != lo_reg) begin
                        rd_addr = AW'(idx_reg - 2'd2);
                        rd_pend_next = 1'b1;
                    end
                end else begin
                    rd_addr = AW'(idx_reg - 1'b1);
                    rd_pend_next = 1'b1;
                end
            end
            ST_WRNEW: begin
                wr_en = 1'b1;
                wr_addr = lo_reg[AW-1:0];
                wr_key = a_reg;
                wr_count = 32'd1;
                state_next = ST_DONE;
            end
            ST_SHL: begin
                // Copy entry idx+(hi-lo) down to idx.
                if (CW'(idx_reg + (hi_reg - lo_reg)) >= occ_reg) begin
                    occ_next = occ_reg - (hi_reg - lo_reg);
                    state_next = ST_DONE;
                end else if (rd_pend_reg) begin
                    wr_en = 1'b1;
                    wr_addr = idx_reg[AW-1:0];
                    idx_next = idx_reg + 1'b1;
                    rd_addr = AW'(idx_reg + 1'b1 + (hi_reg - lo_reg));
                    rd_pend_next = 1'b1;
                end
            end
            ST_DONE: begin
                // Hand the result over once the output register is free.
                if (!mv_reg || m_tready) begin
                    out_load = 1'b1;
                    mv_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (accept) begin
            total_next = '0;
            status_next = smrc_pkg::STATUS_OK;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            occ_reg <= '0;
            mv_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            occ_reg <= occ_next;
            mv_reg <= mv_next;
            rd_pend_reg <= rd_pend_next;
        end
    end

    // Working registers.
    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        lo_found_reg <= lo_found_next;
        sum_reg <= sum_next;
        total_reg <= total_next;
        status_reg <= status_next;
        if (out_load) begin
            out_total_reg <= total_reg;
            out_status_reg <= status_reg;
        end
        if (accept) begin
            mode_reg <= s_tdata[1:0];
            a_reg <= s_tdata[33:2];
            b_reg <= s_tdata[65:34];
        end
    end

endmodule
`default_nettype wire
